// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the frame slot pool RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fspr_pkg.sv =====
// Package for the frame slot pool: field widths, request and status codes,
// controller state type and the command/status structs. No dependencies.
package fspr_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int REQ_W    = 3;
    localparam int GEN_W    = 32;
    localparam int TIME_W   = 64;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam logic [REQ_W-1:0] REQ_TAKE    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_COMMIT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DROP    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_DUE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_CHECK,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic cap_req;
        logic exec;
        logic lookup;
        logic check;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic go_lookup;
        logic ready_empty;
        logic stale;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/core/fspr_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module fspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fspr_ctrl.sv =====
// Controller state machine of the frame slot pool.
// Depends on fspr_pkg and assert_macros.svh; drives cmd_t, reads stat_t.
`include "assert_macros.svh"

module fspr_ctrl
    import fspr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t st,
    output logic  in_ready,
    output cmd_t  cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = st.go_lookup ? S_LOOKUP : S_FINISH;
            end
            S_LOOKUP:
            begin
                state_next = st.ready_empty ? S_FINISH : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = st.stale ? S_LOOKUP : S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.cap_req = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_out = !st.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_IMPL(a_load_when_free, cmd.load_out, !st.out_busy, "result loaded over a held word")
    `ASSERT_NEXT(a_lookup_to_check, state_reg == S_LOOKUP && !st.ready_empty, state_reg == S_CHECK, "head read not checked")
    `ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd), "more than one command active")

endmodule

// ===== rtl/core/fspr_dp.sv =====
// Datapath of the frame slot pool: request latch, free and ready rings,
// pending slot, slot data RAM, result and output registers.
// Depends on fspr_pkg, fspr_ram and assert_macros.svh.
`include "assert_macros.svh"

module fspr_dp
    import fspr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic [REQ_W-1:0]           req_type,
    input  logic [GEN_W-1:0]           frame_gen,
    input  logic signed [TIME_W-1:0]   frame_time,
    input  logic signed [TIME_W-1:0]   due_limit,
    input  logic [SLOT_W-1:0]          slot_in,
    input  logic                       out_ready,
    input  cmd_t                       cmd,
    output stat_t                      st,
    output logic                       out_valid,
    output logic [STATUS_W-1:0]        status,
    output logic [SLOT_W-1:0]          slot_out,
    output logic signed [TIME_W-1:0]   head_time,
    output logic [COUNT_W-1:0]         ready_count,
    output logic [COUNT_W-1:0]         stale_dropped
);

    localparam int CELLS = SLOTS + 1;
    localparam int PW    = $clog2(CELLS);
    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = GEN_W + TIME_W;

    localparam logic [PW-1:0]     LAST_CELL = PW'(CELLS - 1);
    localparam logic [PW:0]       CELLS_W   = (PW + 1)'(CELLS);
    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOTS);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == LAST_CELL) ? '0 : p + 1'b1;
    endfunction

    logic [REQ_W-1:0]  req_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] due_reg;
    logic [SLOT_W-1:0] slot_in_reg;

    logic              enable_reg, enable_next;
    logic [SW-1:0]     free_ring_reg [CELLS];
    logic [PW-1:0]     free_wr_reg, free_wr_next;
    logic [PW-1:0]     free_rd_reg, free_rd_next;
    logic [SW-1:0]     ready_ring_reg [CELLS];
    logic [PW-1:0]     ready_wr_reg, ready_wr_next;
    logic [PW-1:0]     ready_rd_reg, ready_rd_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SW-1:0]     pend_slot_reg, pend_slot_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [TIME_W-1:0]   res_time_reg, res_time_next;
    logic [COUNT_W-1:0]  stale_reg, stale_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [COUNT_W-1:0]  out_stale_reg;

    logic          free_clear;
    logic          push_req;
    logic [SW-1:0] push_slot;
    logic          push_do;
    logic          ready_we;
    logic          ram_we;
    logic [DW-1:0] ram_rdata;
    logic [SW-1:0] head_slot;
    logic          ready_empty;
    logic          free_empty;
    logic          free_full;
    logic          gen_mismatch;
    logic          not_due;
    logic [PW:0]   count_wide;

    assign head_slot    = ready_ring_reg[ready_rd_reg];
    assign ready_empty  = ready_rd_reg == ready_wr_reg;
    assign free_empty   = free_rd_reg == free_wr_reg;
    assign free_full    = ring_next(free_wr_reg) == free_rd_reg;
    assign gen_mismatch = ram_rdata[DW-1:TIME_W] != gen_reg;
    assign not_due      = $signed(ram_rdata[TIME_W-1:0]) > $signed(due_reg);
    assign count_wide   = (ready_wr_reg >= ready_rd_reg)
                        ? {1'b0, ready_wr_reg} - {1'b0, ready_rd_reg}
                        : {1'b0, ready_wr_reg} + CELLS_W - {1'b0, ready_rd_reg};
    assign push_do      = push_req && !free_full;

    fspr_ram #(
        .WIDTH(DW),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pend_slot_reg),
        .wdata({gen_reg, time_reg}),
        .re   (cmd.lookup),
        .raddr(head_slot),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        enable_next     = enable_reg;
        free_wr_next    = free_wr_reg;
        free_rd_next    = free_rd_reg;
        ready_wr_next   = ready_wr_reg;
        ready_rd_next   = ready_rd_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_time_next   = res_time_reg;
        stale_next      = stale_reg;
        free_clear      = 1'b0;
        push_req        = 1'b0;
        push_slot       = head_slot;
        ready_we        = 1'b0;
        ram_we          = 1'b0;

        if (cmd.exec)
        begin
            res_status_next = ST_IGNORED;
            res_slot_next   = SLOT_NONE;
            res_time_next   = '0;
            stale_next      = '0;
            if (enable_reg)
            begin
                unique case (req_reg)
                    REQ_TAKE:
                    begin
                        if (pend_valid_reg)
                        begin
                            res_status_next = ST_OK;
                            res_slot_next   = SLOT_W'(pend_slot_reg);
                        end
                        else if (free_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            free_rd_next    = ring_next(free_rd_reg);
                            pend_valid_next = 1'b1;
                            pend_slot_next  = free_ring_reg[free_rd_reg];
                            res_status_next = ST_OK;
                            res_slot_next   = SLOT_W'(free_ring_reg[free_rd_reg]);
                        end
                    end
                    REQ_COMMIT:
                    begin
                        if (pend_valid_reg && ring_next(ready_wr_reg) != ready_rd_reg)
                        begin
                            ram_we          = 1'b1;
                            ready_we        = 1'b1;
                            ready_wr_next   = ring_next(ready_wr_reg);
                            pend_valid_next = 1'b0;
                            res_status_next = ST_OK;
                        end
                    end
                    REQ_ACQUIRE, REQ_PEEK:
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    REQ_DROP:
                    begin
                        if (ready_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ready_rd_next   = ring_next(ready_rd_reg);
                            push_req        = 1'b1;
                            res_status_next = ST_OK;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (slot_in_reg < SLOT_NONE)
                        begin
                            push_req  = 1'b1;
                            push_slot = slot_in_reg[SW-1:0];
                            if (!free_full)
                            begin
                                res_status_next = ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_IGNORED;
                    end
                endcase
            end
        end

        if (cmd.check)
        begin
            if (req_reg == REQ_PEEK)
            begin
                res_status_next = ST_OK;
                res_time_next   = ram_rdata[TIME_W-1:0];
            end
            else if (gen_mismatch)
            begin
                ready_rd_next = ring_next(ready_rd_reg);
                push_req      = 1'b1;
                stale_next    = stale_reg + 1'b1;
            end
            else if (not_due)
            begin
                res_status_next = ST_NOT_DUE;
            end
            else
            begin
                ready_rd_next   = ring_next(ready_rd_reg);
                res_status_next = ST_OK;
                res_slot_next   = SLOT_W'(head_slot);
                res_time_next   = ram_rdata[TIME_W-1:0];
            end
        end

        if (push_do)
        begin
            free_wr_next = ring_next(free_wr_reg);
        end

        if (cfg_we)
        begin
            enable_next = cfg_wdata;
            if (cfg_wdata)
            begin
                free_clear      = 1'b1;
                free_wr_next    = PW'(SLOTS);
                free_rd_next    = '0;
                ready_wr_next   = '0;
                ready_rd_next   = '0;
                pend_valid_next = 1'b0;
            end
        end

        out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            free_wr_reg    <= PW'(SLOTS);
            free_rd_reg    <= '0;
            ready_wr_reg   <= '0;
            ready_rd_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < CELLS; i++)
            begin
                free_ring_reg[i] <= (i < SLOTS) ? SW'(i) : '0;
            end
        end
        else
        begin
            enable_reg     <= enable_next;
            free_wr_reg    <= free_wr_next;
            free_rd_reg    <= free_rd_next;
            ready_wr_reg   <= ready_wr_next;
            ready_rd_reg   <= ready_rd_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (free_clear)
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    free_ring_reg[i] <= (i < SLOTS) ? SW'(i) : '0;
                end
            end
            else if (push_do)
            begin
                free_ring_reg[free_wr_reg] <= push_slot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg     <= req_type;
            gen_reg     <= frame_gen;
            time_reg    <= frame_time;
            due_reg     <= due_limit;
            slot_in_reg <= slot_in;
        end
        if (ready_we)
        begin
            ready_ring_reg[ready_wr_reg] <= pend_slot_reg;
        end
        pend_slot_reg  <= pend_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_time_reg   <= res_time_next;
        stale_reg      <= stale_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_time_reg   <= res_time_reg;
            out_count_reg  <= COUNT_W'(count_wide);
            out_stale_reg  <= stale_reg;
        end
    end

    assign st.go_lookup   = enable_reg && (req_reg == REQ_ACQUIRE || req_reg == REQ_PEEK);
    assign st.ready_empty = ready_empty;
    assign st.stale       = req_reg == REQ_ACQUIRE && gen_mismatch;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot_out      = out_slot_reg;
    assign head_time     = out_time_reg;
    assign ready_count   = out_count_reg;
    assign stale_dropped = out_stale_reg;

    `ASSERT_ALWAYS(a_count_bound, count_wide <= (PW + 1)'(SLOTS), "ready ring over capacity")
    `ASSERT_NEXT(a_disabled_frozen, cmd.exec && !enable_reg && !cfg_we, $stable(ready_rd_reg) && $stable(free_wr_reg) && $stable(pend_valid_reg), "disabled pool changed state")
    `ASSERT_IMPL(a_stale_bound, cmd.check, stale_reg < COUNT_W'(SLOTS), "stale count past pool size")

endmodule

// ===== rtl/core/frame_slot_pool_ring_unit.sv =====
// Take, commit, drop, release, ignored: accepted in S_IDLE, run in S_EXEC, then S_FINISH.
// Acquire, peek: S_EXEC, then S_LOOKUP and S_CHECK per head frame read (acquire recycles stale
// ones), then S_FINISH; no S_CHECK if the ready ring is empty. Requests are taken in S_IDLE only.
// Outputs are registered; a new word is accepted while the last result is still held.
// Reset (rst_n, async low): pool disabled; a write of 1 frees all slots.
// Top level of the frame slot pool; depends on fspr_pkg, fspr_ctrl, fspr_dp.
module frame_slot_pool_ring_unit
    import fspr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [GEN_W-1:0]         frame_gen,
    input  logic signed [TIME_W-1:0] frame_time,
    input  logic signed [TIME_W-1:0] due_limit,
    input  logic [SLOT_W-1:0]        slot_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        slot_out,
    output logic signed [TIME_W-1:0] head_time,
    output logic [COUNT_W-1:0]       ready_count,
    output logic [COUNT_W-1:0]       stale_dropped
);

    cmd_t  cmd;
    stat_t st;

    fspr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .st      (st),
        .in_ready(in_ready),
        .cmd     (cmd)
    );

    fspr_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .frame_gen    (frame_gen),
        .frame_time   (frame_time),
        .due_limit    (due_limit),
        .slot_in      (slot_in),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .status       (status),
        .slot_out     (slot_out),
        .head_time    (head_time),
        .ready_count  (ready_count),
        .stale_dropped(stale_dropped)
    );

endmodule
